// ----- rtl/imcol_pkg.sv -----
// Shared constants, types and register clamp helpers for the im2col unroller.
package imcol_pkg;

   localparam int STORE_DEPTH  = 4096;
   localparam int WORD_BITS    = 32;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS    = 9;

   localparam logic [2:0] CSR_BATCH_COUNT   = 3'd0;
   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd1;
   localparam logic [2:0] CSR_IMAGE_HEIGHT  = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_KERNEL_SIDE   = 3'd4;
   localparam logic [2:0] CSR_STEP_SIZE     = 3'd5;
   localparam logic [2:0] CSR_PAD_AMOUNT    = 3'd6;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_RESTART = 2'd1,
      OP_FETCH   = 2'd2
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ADDR_BITS-1:0]   addr;
      logic [WORD_BITS-1:0]   word;
   } qitem_type;

   typedef struct packed {
      logic [4:0] batch_count;
      logic [6:0] channel_count;
      logic [8:0] image_height;
      logic [8:0] image_width;
      logic [3:0] kernel_side;
      logic [3:0] step_size;
      logic [2:0] pad_amount;
   } cfg_type;

   function automatic logic [4:0] clamp_batch(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      if (v == 5'd0) r = 5'd1;
      else if (v > 5'd16) r = 5'd16;
      return r;
   endfunction

   function automatic logic [6:0] clamp_channel(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (v > 7'd64) r = 7'd64;
      return r;
   endfunction

   function automatic logic [8:0] clamp_side(input logic [8:0] v);
      logic [8:0] r;
      r = v;
      if (v == 9'd0) r = 9'd1;
      else if (v > 9'd256) r = 9'd256;
      return r;
   endfunction

   function automatic logic [3:0] clamp_nz4(input logic [3:0] v);
      return (v == 4'd0) ? 4'd1 : v;
   endfunction

endpackage

// ----- rtl/imcol_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module imcol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/imcol_front.sv -----
// Request front end: accepts requests, drops unknown opcodes, queues the rest.
module imcol_front import imcol_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_load_address,
   input  logic [31:0] req_load_word,
   output logic        q_valid,
   output qitem_type   q_item,
   input  logic        q_pop
);

   qitem_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 known;
   logic                 push;
   qitem_type            item;

   always_comb begin
      case (op_type'(req_opcode))
         OP_LOAD, OP_RESTART, OP_FETCH: known = 1'b1;
         default:                       known = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   // unknown opcodes are taken off the channel but never queued
   assign push      = req_valid && !req_stall && known;

   assign item.op   = op_type'(req_opcode);
   assign item.addr = ADDR_BITS'(req_load_address);
   assign item.word = WORD_BITS'(req_load_word);

   assign wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);

   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/imcol_back.sv -----
// Execution back end: image store, output-size divider, walk counters, result register.
module imcol_back import imcol_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  qitem_type   q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_element_word,
   output logic [20:0] rsp_matrix_row,
   output logic [13:0] rsp_matrix_column,
   output logic        rsp_is_padding,
   output logic        rsp_last_element,
   output logic        rsp_done_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADDR1,
      ST_ADDR2,
      ST_ADDR3,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // walk state
   logic [3:0] batch_ff, batch_in;
   logic [8:0] oy_ff, oy_in;
   logic [8:0] ox_ff, ox_in;
   logic [5:0] chan_ff, chan_in;
   logic [3:0] ky_ff, ky_in;
   logic [3:0] kx_ff, kx_in;
   logic [8:0] out_h_ff, out_h_in;
   logic [8:0] out_w_ff, out_w_in;
   logic       finished_ff, finished_in;

   // divider
   logic [8:0] num_h_ff, num_h_in, num_w_ff, num_w_in;
   logic [3:0] rem_h_ff, rem_h_in, rem_w_ff, rem_w_in;
   logic [3:0] div_cnt_ff, div_cnt_in;

   // address / index pipeline
   logic signed [13:0]   ih_ff, ih_in, iw_ff, iw_in;
   logic [10:0]          t1_ff, t1_in;
   logic [13:0]          r1_ff, r1_in;
   logic [9:0]           c1_ff, c1_in;
   logic [19:0]          a2_ff, a2_in;
   logic [20:0]          row_ff, row_in;
   logic [13:0]          col_ff, col_in;
   logic                 pad_ff, pad_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 done_pend_ff, done_pend_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [20:0] rsp_row_ff, rsp_row_in;
   logic [13:0] rsp_col_ff, rsp_col_in;
   logic        rsp_pad_ff, rsp_pad_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;

   logic                 ram_we, ram_re;
   logic [WORD_BITS-1:0] ram_rdata;

   logic [4:0] bn;
   logic [6:0] cn;
   logic [8:0] h, w, ph, pw;
   logic [3:0] k, s;
   logic [2:0] p;
   logic       too_big;

   logic [4:0] trial_h, trial_w;
   logic       ge_h, ge_w;
   logic [3:0] rem_h_step, rem_w_step;
   logic [8:0] num_h_step, num_w_step;

   logic [12:0] yy, xx;
   logic [22:0] row_full;
   logic [28:0] lin;

   logic kx_wrap, ky_wrap, ch_wrap, ox_wrap, oy_wrap, b_wrap, last;
   logic out_free;

   imcol_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_item.addr),
      .wr_data (q_item.word),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign bn = clamp_batch(cfg.batch_count);
   assign cn = clamp_channel(cfg.channel_count);
   assign h  = clamp_side(cfg.image_height);
   assign w  = clamp_side(cfg.image_width);
   assign k  = clamp_nz4(cfg.kernel_side);
   assign s  = clamp_nz4(cfg.step_size);
   assign p  = cfg.pad_amount;

   assign ph      = h + {5'b0, p, 1'b0};
   assign pw      = w + {5'b0, p, 1'b0};
   assign too_big = ({5'b0, k} > ph) || ({5'b0, k} > pw);

   // one restoring-division bit per cycle, height and width side by side
   assign trial_h    = {rem_h_ff, num_h_ff[8]};
   assign trial_w    = {rem_w_ff, num_w_ff[8]};
   assign ge_h       = trial_h >= {1'b0, s};
   assign ge_w       = trial_w >= {1'b0, s};
   assign rem_h_step = ge_h ? 4'(trial_h - {1'b0, s}) : trial_h[3:0];
   assign rem_w_step = ge_w ? 4'(trial_w - {1'b0, s}) : trial_w[3:0];
   assign num_h_step = {num_h_ff[7:0], ge_h};
   assign num_w_step = {num_w_ff[7:0], ge_w};

   assign yy       = {4'b0, oy_ff} * {9'b0, s} + {9'b0, ky_ff};
   assign xx       = {4'b0, ox_ff} * {9'b0, s} + {9'b0, kx_ff};
   assign row_full = {9'b0, r1_ff} * {14'b0, out_w_ff} + {14'b0, ox_ff};
   assign lin      = {9'b0, a2_ff} * {20'b0, w} + {20'b0, iw_ff[8:0]};

   // innermost counter first; each wraps only when the one inside it wraps
   assign kx_wrap = ({1'b0, kx_ff} + 5'd1) >= {1'b0, k};
   assign ky_wrap = ({1'b0, ky_ff} + 5'd1) >= {1'b0, k};
   assign ch_wrap = ({1'b0, chan_ff} + 7'd1) >= cn;
   assign ox_wrap = ({1'b0, ox_ff} + 10'd1) >= {1'b0, out_w_ff};
   assign oy_wrap = ({1'b0, oy_ff} + 10'd1) >= {1'b0, out_h_ff};
   assign b_wrap  = ({1'b0, batch_ff} + 5'd1) >= bn;
   assign last    = kx_wrap && ky_wrap && ch_wrap && ox_wrap && oy_wrap && b_wrap;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      batch_in     = batch_ff;
      oy_in        = oy_ff;
      ox_in        = ox_ff;
      chan_in      = chan_ff;
      ky_in        = ky_ff;
      kx_in        = kx_ff;
      out_h_in     = out_h_ff;
      out_w_in     = out_w_ff;
      finished_in  = finished_ff;
      num_h_in     = num_h_ff;
      num_w_in     = num_w_ff;
      rem_h_in     = rem_h_ff;
      rem_w_in     = rem_w_ff;
      div_cnt_in   = div_cnt_ff;
      ih_in        = ih_ff;
      iw_in        = iw_ff;
      t1_in        = t1_ff;
      r1_in        = r1_ff;
      c1_in        = c1_ff;
      a2_in        = a2_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pad_in       = pad_ff;
      addr_in      = addr_ff;
      done_pend_in = done_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pad_in   = rsp_pad_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  OP_RESTART: begin
                     batch_in = '0;
                     oy_in    = '0;
                     ox_in    = '0;
                     chan_in  = '0;
                     ky_in    = '0;
                     kx_in    = '0;
                     if (too_big) begin
                        out_h_in    = '0;
                        out_w_in    = '0;
                        finished_in = 1'b1;
                     end else begin
                        num_h_in   = ph - {5'b0, k};
                        num_w_in   = pw - {5'b0, k};
                        rem_h_in   = '0;
                        rem_w_in   = '0;
                        div_cnt_in = '0;
                        state_in   = ST_DIV;
                     end
                  end
                  OP_FETCH: begin
                     done_pend_in = finished_ff;
                     state_in     = finished_ff ? ST_EMIT : ST_ADDR1;
                  end
                  default: ;
               endcase
            end
         end

         ST_DIV: begin
            num_h_in   = num_h_step;
            num_w_in   = num_w_step;
            rem_h_in   = rem_h_step;
            rem_w_in   = rem_w_step;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(DIV_STEPS - 1)) begin
               out_h_in    = num_h_step + 9'd1;
               out_w_in    = num_w_step + 9'd1;
               finished_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         ST_ADDR1: begin
            ih_in    = $signed({1'b0, yy}) - $signed({11'b0, p});
            iw_in    = $signed({1'b0, xx}) - $signed({11'b0, p});
            t1_in    = {7'b0, batch_ff} * {4'b0, cn} + {5'b0, chan_ff};
            r1_in    = {10'b0, batch_ff} * {5'b0, out_h_ff} + {5'b0, oy_ff};
            c1_in    = {4'b0, chan_ff} * {6'b0, k} + {6'b0, ky_ff};
            state_in = ST_ADDR2;
         end

         ST_ADDR2: begin
            pad_in   = (ih_ff < 14'sd0) || (iw_ff < 14'sd0) ||
                       (ih_ff >= $signed({5'b0, h})) || (iw_ff >= $signed({5'b0, w}));
            a2_in    = {9'b0, t1_ff} * {11'b0, h} + {11'b0, ih_ff[8:0]};
            row_in   = row_full[20:0];
            col_in   = {4'b0, c1_ff} * {10'b0, k} + {10'b0, kx_ff};
            state_in = ST_ADDR3;
         end

         ST_ADDR3: begin
            // store depth is a power of two: wrap by dropping upper bits
            addr_in  = ADDR_BITS'(lin);
            state_in = ST_READ;
         end

         ST_READ: begin
            ram_re   = !pad_ff;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (done_pend_ff) begin
                  rsp_word_in = '0;
                  rsp_row_in  = '0;
                  rsp_col_in  = '0;
                  rsp_pad_in  = 1'b0;
                  rsp_last_in = 1'b0;
                  rsp_done_in = 1'b1;
               end else begin
                  rsp_word_in = pad_ff ? 32'd0 : 32'(ram_rdata);
                  rsp_row_in  = row_ff;
                  rsp_col_in  = col_ff;
                  rsp_pad_in  = pad_ff;
                  rsp_last_in = last;
                  rsp_done_in = 1'b0;
                  kx_in = kx_wrap ? 4'd0 : kx_ff + 4'd1;
                  if (kx_wrap) begin
                     ky_in = ky_wrap ? 4'd0 : ky_ff + 4'd1;
                  end
                  if (kx_wrap && ky_wrap) begin
                     chan_in = ch_wrap ? 6'd0 : chan_ff + 6'd1;
                  end
                  if (kx_wrap && ky_wrap && ch_wrap) begin
                     ox_in = ox_wrap ? 9'd0 : ox_ff + 9'd1;
                  end
                  if (kx_wrap && ky_wrap && ch_wrap && ox_wrap) begin
                     oy_in = oy_wrap ? 9'd0 : oy_ff + 9'd1;
                  end
                  if (kx_wrap && ky_wrap && ch_wrap && ox_wrap && oy_wrap) begin
                     batch_in = b_wrap ? 4'd0 : batch_ff + 4'd1;
                  end
                  if (last) begin
                     finished_in = 1'b1;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_h_ff     <= num_h_in;
      num_w_ff     <= num_w_in;
      rem_h_ff     <= rem_h_in;
      rem_w_ff     <= rem_w_in;
      ih_ff        <= ih_in;
      iw_ff        <= iw_in;
      t1_ff        <= t1_in;
      r1_ff        <= r1_in;
      c1_ff        <= c1_in;
      a2_ff        <= a2_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      pad_ff       <= pad_in;
      addr_ff      <= addr_in;
      done_pend_ff <= done_pend_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_pad_ff   <= rsp_pad_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         batch_ff     <= '0;
         oy_ff        <= '0;
         ox_ff        <= '0;
         chan_ff      <= '0;
         ky_ff        <= '0;
         kx_ff        <= '0;
         out_h_ff     <= '0;
         out_w_ff     <= '0;
         finished_ff  <= 1'b1;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         batch_ff     <= batch_in;
         oy_ff        <= oy_in;
         ox_ff        <= ox_in;
         chan_ff      <= chan_in;
         ky_ff        <= ky_in;
         kx_ff        <= kx_in;
         out_h_ff     <= out_h_in;
         out_w_ff     <= out_w_in;
         finished_ff  <= finished_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_word  = rsp_word_ff;
   assign rsp_matrix_row    = rsp_row_ff;
   assign rsp_matrix_column = rsp_col_ff;
   assign rsp_is_padding    = rsp_pad_ff;
   assign rsp_last_element  = rsp_last_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule

// ----- rtl/im2col_patch_unroller_core.sv -----
// Top level of the im2col patch unroller: configuration registers, front end and back end.
//
// Usage: the req_ channel carries load (store one word at an address), restart (latch the
// output size and rewind the walk) and fetch (emit the next unrolled patch element)
// requests. Opcode 3 is taken and dropped. Only a fetch produces a result on the rsp_
// channel; past the end of the walk, or before any restart, the result has rsp_done_res
// set and all other fields zero. The user must write configuration registers through csr_ only
// while no request is in flight; the block itself does not enforce it.
// Requests pass through a four-entry queue, so req_stall rises only when it is full.
// The back end runs one request at a time: a load writes one store word, a restart runs the
// nine-step shift-subtract divider for the output height and width (skipped when the
// kernel does not fit the padded image), and a fetch passes through one dispatch, three
// multiply stages for the store address and matrix indexes, one store read and one result
// load (only the dispatch and the result load once the walk has finished).
// The result sits in an output register; while rsp_stall is high it holds, the back end
// waits with the next result, and the queue keeps taking requests until full.
// Reset empties the queue, restores the register defaults and marks the walk finished.
// Store contents are not cleared; no entry may be read before it is loaded.
module im2col_patch_unroller_core import imcol_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_load_address,
   input  logic [31:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_element_word,
   output logic [20:0] rsp_matrix_row,
   output logic [13:0] rsp_matrix_column,
   output logic        rsp_is_padding,
   output logic        rsp_last_element,
   output logic        rsp_done_res,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   qitem_type q_item;
   logic      q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BATCH_COUNT:   cfg_in.batch_count   = csr_wdata[4:0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[6:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata;
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata;
            CSR_KERNEL_SIDE:   cfg_in.kernel_side   = csr_wdata[3:0];
            CSR_STEP_SIZE:     cfg_in.step_size     = csr_wdata[3:0];
            CSR_PAD_AMOUNT:    cfg_in.pad_amount    = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.batch_count   <= 5'd1;
         cfg_ff.channel_count <= 7'd1;
         cfg_ff.image_height  <= 9'd8;
         cfg_ff.image_width   <= 9'd8;
         cfg_ff.kernel_side   <= 4'd3;
         cfg_ff.step_size     <= 4'd1;
         cfg_ff.pad_amount    <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   imcol_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_load_address (req_load_address),
      .req_load_word    (req_load_word),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   imcol_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_word  (rsp_element_word),
      .rsp_matrix_row    (rsp_matrix_row),
      .rsp_matrix_column (rsp_matrix_column),
      .rsp_is_padding    (rsp_is_padding),
      .rsp_last_element  (rsp_last_element),
      .rsp_done_res      (rsp_done_res)
   );

endmodule
